@@ sv/ecct_pkg.sv @@
// ---------------------------------------------------------------------------
// ecct_pkg: shared types and constants of the event camera cluster tracker
// Register indexes, status codes, packet formats and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package ecct_pkg;

    localparam logic [2:0] REG_FORMAT    = 3'd0;
    localparam logic [2:0] REG_RADIUS    = 3'd1;
    localparam logic [2:0] REG_KEEP      = 3'd2;
    localparam logic [2:0] REG_NEW       = 3'd3;
    localparam logic [2:0] REG_GAIN      = 3'd4;
    localparam logic [2:0] REG_OFFSET    = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_SYNC     = 2'd1;
    localparam logic [1:0] ST_BACKWARD = 2'd2;

    localparam logic [2:0] FMT_TWO  = 3'd0;
    localparam logic [2:0] FMT_VAR  = 3'd1;
    localparam logic [2:0] FMT_TS16 = 3'd2;
    localparam logic [2:0] FMT_TS24 = 3'd3;

    localparam logic [14:0] TRACK_RESET = 15'd16384;
    localparam logic [14:0] TRACK_MAX   = 15'd32767;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAME,
        S_DX,
        S_DY,
        S_CMP,
        S_BX0,
        S_BX1,
        S_BY0,
        S_BY1,
        S_POS,
        S_ERR,
        S_DONE
    } seq_state_t;

    // multiplier operand select
    typedef enum logic [2:0] {
        M_DX,
        M_DY,
        M_KX,
        M_NX,
        M_KY,
        M_NY,
        M_POS
    } mul_sel_t;

    typedef struct packed {
        logic [2:0]  packet_format;
        logic [15:0] radius_squared;
        logic [15:0] keep_weight;
        logic [15:0] new_weight;
        logic signed [23:0] mm_per_pixel;
        logic signed [23:0] mm_offset;
        logic [22:0] event_threshold;
    } cfg_t;

endpackage
`default_nettype wire

@@ sv/ecct_mul.sv @@
// ---------------------------------------------------------------------------
// ecct_mul: shared registered multiplier
// One signed 25 x 25 product a cycle, result registered.
// ---------------------------------------------------------------------------
`default_nettype none
module ecct_mul
    import ecct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [24:0] a,
    input  wire logic signed [24:0] b,
    output logic signed [49:0]      p
);
    logic signed [49:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

@@ sv/event_camera_cluster_tracker.sv @@
// Sequencing: a byte that completes no packet is framed and the input freed; a
//   byte that completes a packet is framed and, if valid, passed through the
//   distance, compare, blend, position and error steps before its result is loaded.
// Input: no new byte is taken until the last one is through, and a waiting result
//   that is stalled holds it; the pace is set by the single shared multiplier
//   stepped through distance, blend and conversion products by the sequencer.
// Reset: asynchronous active low; registers take their reset values, the
//   byte window empties, the track returns to pixel 64.0.
// ---------------------------------------------------------------------------
// event_camera_cluster_tracker: packet framer and cluster tracker
// Frames camera bytes into packets, checks sync and stamp order, updates an
// exponential cluster and reports its position in millimetres.
// ---------------------------------------------------------------------------
`default_nettype none
module event_camera_cluster_tracker
    import ecct_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beats
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  stream_byte,
    input  wire logic signed [23:0] setpoint_mm,
    // result beats
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [6:0]       pixel_x,
    output logic [6:0]       pixel_y,
    output logic             polarity,
    output logic [31:0]      stamp,
    output logic             in_cluster,
    output logic [14:0]      cluster_x,
    output logic [14:0]      cluster_y,
    output logic signed [23:0] position_mm,
    output logic             send_event,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    localparam int DEPTH = 6;
    localparam int CAP = (MAX_PACKET_BYTES < DEPTH) ? MAX_PACKET_BYTES : DEPTH;
    localparam logic [2:0] CAP3 = 3'(CAP);

    cfg_t cfg_reg;

    logic [7:0]  win_reg [DEPTH];
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] last_reg;
    logic [14:0] tx_reg, ty_reg;
    logic signed [23:0] setp_reg;

    seq_state_t state_reg, state_next;

    // packet registers captured at framing
    logic [1:0]  stat_reg;
    logic [6:0]  px_reg, py_reg;
    logic        pol_reg;
    logic [31:0] stamp_reg;
    logic        incl_reg;
    logic signed [49:0] acc_reg;
    logic signed [25:0] pos_reg;
    logic        ev_reg;
    logic        out_valid_reg;

    // ------------------------------------------------------------------
    // Window byte reads, zero beyond the fill
    // ------------------------------------------------------------------
    function automatic logic [7:0] wb(input logic [7:0] w [DEPTH], input logic [2:0] f,
                                      input int i);
        if (i < DEPTH && 3'(i) < f)
            return w[i];
        return 8'd0;
    endfunction

    // ------------------------------------------------------------------
    // Framing: combinational view of the window after the byte landed
    // ------------------------------------------------------------------
    logic [2:0]  plen;
    logic [6:0]  fx, fy;
    logic        fpol, fsync, fback;
    logic [31:0] fstamp;
    logic [2:0]  fmt;

    always_comb
    begin
        logic [2:0] need;
        logic       mark;
        logic [7:0] b;
        logic [7:0] b0;
        logic [7:0] b1;
        need = 3'd6;
        b = 8'd0;
        fmt = (cfg_reg.packet_format > 3'd4) ? 3'd4 : cfg_reg.packet_format;
        plen = 3'd0;
        if (fmt == FMT_VAR)
        begin
            for (int i = 3; i <= 6; i++)
            begin
                b = wb(win_reg, fill_reg, i - 1);
                if (plen == 3'd0 && 3'(i) <= fill_reg && i <= CAP && b[7])
                    plen = 3'(i);
            end
            if (plen == 3'd0 && fill_reg >= CAP3)
                plen = CAP3;
        end
        else
        begin
            case (fmt)
                FMT_TWO:  need = 3'd2;
                FMT_TS16: need = 3'd4;
                FMT_TS24: need = 3'd5;
                default:  need = 3'd6;
            endcase
            if (need > CAP3)
                need = CAP3;
            plen = (fill_reg >= need) ? need : 3'd0;
        end

        b0 = wb(win_reg, fill_reg, 0);
        b1 = wb(win_reg, fill_reg, 1);
        fpol  = b1[7];
        fsync = b0[7];
        if (fmt == FMT_TWO)
        begin
            fx = b0[6:0];
            fy = b1[6:0];
        end
        else
        begin
            fy = b0[6:0];
            fx = b1[6:0];
        end
        fstamp = 32'd0;
        mark = 1'b0;
        case (fmt)
            FMT_TWO: fstamp = 32'd0;
            FMT_VAR:
            begin
                b = wb(win_reg, fill_reg, 2);
                fstamp = {25'd0, b[6:0]};
                mark = b[7];
                for (int i = 3; i < 6; i++)
                begin
                    if (3'(i) < plen)
                    begin
                        b = wb(win_reg, fill_reg, i);
                        fstamp = {fstamp[23:0], 8'd0} + {25'd0, b[6:0]};
                        mark = b[7];
                    end
                end
                fsync = fsync & mark;
            end
            FMT_TS16: fstamp = {16'd0, wb(win_reg, fill_reg, 2), wb(win_reg, fill_reg, 3)};
            FMT_TS24: fstamp = {8'd0, wb(win_reg, fill_reg, 2), wb(win_reg, fill_reg, 3),
                                wb(win_reg, fill_reg, 4)};
            default:
            begin
                fstamp = {wb(win_reg, fill_reg, 2), wb(win_reg, fill_reg, 3),
                          wb(win_reg, fill_reg, 4), wb(win_reg, fill_reg, 5)};
                fsync = ~fsync;
            end
        endcase
        fback = (fmt != FMT_TWO) && (fstamp < last_reg);
    end

    // ------------------------------------------------------------------
    // Shared multiplier and operand selection
    // ------------------------------------------------------------------
    mul_sel_t msel;
    logic signed [24:0] ma, mb;
    logic signed [49:0] mp;
    logic signed [24:0] dxs, dys;
    logic [6:0]         dpx;

    // the column register loads at the end of framing; take the framed column then
    assign dpx = (state_reg == S_FRAME) ? fx : px_reg;
    assign dxs = 25'(signed'({1'b0, tx_reg})) - 25'(signed'({1'b0, dpx, 8'd0}));
    assign dys = 25'(signed'({1'b0, ty_reg})) - 25'(signed'({1'b0, py_reg, 8'd0}));

    always_comb
    begin
        case (msel)
            M_DX:    begin ma = dxs; mb = dxs; end
            M_DY:    begin ma = dys; mb = dys; end
            M_KX:    begin ma = 25'(tx_reg); mb = 25'(cfg_reg.keep_weight); end
            M_NX:    begin ma = 25'({px_reg, 8'd0}); mb = 25'(cfg_reg.new_weight); end
            M_KY:    begin ma = 25'(ty_reg); mb = 25'(cfg_reg.keep_weight); end
            M_NY:    begin ma = 25'({py_reg, 8'd0}); mb = 25'(cfg_reg.new_weight); end
            default: begin ma = 25'(tx_reg); mb = 25'(cfg_reg.mm_per_pixel); end
        endcase
    end

    ecct_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_FRAME;
            S_FRAME:
                if (plen == 3'd0)      state_next = S_IDLE;
                else if (fsync || fback) state_next = S_DONE;
                else                   state_next = S_DX;
            S_DX:    state_next = S_DY;
            S_DY:    state_next = S_CMP;
            S_CMP:   state_next = S_BX0;
            S_BX0:   state_next = S_BX1;
            S_BX1:   state_next = S_BY0;
            S_BY0:   state_next = S_BY1;
            S_BY1:   state_next = S_POS;
            S_POS:   state_next = S_ERR;
            S_ERR:   state_next = S_DONE;
            S_DONE:  if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs (multiplier selects for the product in flight)
    always_comb
    begin
        case (state_reg)
            S_FRAME: msel = M_DX;
            S_DX:    msel = M_DY;
            S_CMP:   msel = M_KX;
            S_BX0:   msel = M_NX;
            S_BX1:   msel = M_KY;
            S_BY0:   msel = M_NY;
            S_BY1:   msel = M_POS;
            default: msel = M_POS;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // window update after the packet resolves
    logic [2:0] drop;
    always_comb
    begin
        drop = (fsync) ? 3'd1 : plen;
    end

    // blend saturation of the accumulator
    logic [33:0] bsum;
    logic [14:0] bsat;
    always_comb
    begin
        bsum = 34'(acc_reg[33:0]) + 34'(mp[33:0]) + 34'd32768;
        bsat = (bsum[33:16] > 18'(TRACK_MAX)) ? TRACK_MAX : bsum[30:16];
    end

    // position: floor((p + 2^15) / 2^16) + offset
    logic signed [49:0] prnd;
    logic signed [25:0] pos_next;
    always_comb
    begin
        prnd = mp + 50'sd32768;
        pos_next = 26'(prnd >>> 16) + 26'(cfg_reg.mm_offset);
    end

    logic signed [26:0] perr;
    assign perr = 27'(setp_reg) - 27'(pos_reg);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= 3'd0;
            last_reg      <= 32'd0;
            tx_reg        <= TRACK_RESET;
            ty_reg        <= TRACK_RESET;
            out_valid_reg <= 1'b0;
            cfg_reg.packet_format   <= 3'd4;
            cfg_reg.radius_squared  <= 16'd100;
            cfg_reg.keep_weight     <= 16'd58982;
            cfg_reg.new_weight      <= 16'd6553;
            cfg_reg.mm_per_pixel    <= 24'sd65536;
            cfg_reg.mm_offset       <= 24'sd0;
            cfg_reg.event_threshold <= 23'd256;
        end
        else
        begin
            state_reg <= state_next;
            // load a new result beat, or drop the one just taken
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FORMAT:    cfg_reg.packet_format   <= cfg_data[2:0];
                    REG_RADIUS:    cfg_reg.radius_squared  <= cfg_data[15:0];
                    REG_KEEP:      cfg_reg.keep_weight     <= cfg_data[15:0];
                    REG_NEW:       cfg_reg.new_weight      <= cfg_data[15:0];
                    REG_GAIN:      cfg_reg.mm_per_pixel    <= cfg_data;
                    REG_OFFSET:    cfg_reg.mm_offset       <= cfg_data;
                    REG_THRESHOLD: cfg_reg.event_threshold <= cfg_data[22:0];
                    default: ;
                endcase
            end
            // land the byte; a full window overwrites its last slot
            if (state_reg == S_IDLE && in_valid && fill_reg < CAP3)
                fill_reg <= fill_reg + 3'd1;
            if (state_reg == S_FRAME && plen != 3'd0)
            begin
                fill_reg <= fill_next;
                if (fback)
                    last_reg <= 32'd0;
                else if (!fsync && fmt != FMT_TWO)
                    last_reg <= fstamp;
            end
            if (state_reg == S_BX1 && incl_reg) tx_reg <= bsat;
            if (state_reg == S_BY1 && incl_reg) ty_reg <= bsat;
        end
    end

    assign fill_next = (drop > fill_reg) ? 3'd0 : fill_reg - drop;

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            setp_reg <= setpoint_mm;
            if (fill_reg < CAP3)
                win_reg[fill_reg] <= stream_byte;
            else
                win_reg[DEPTH - 1] <= stream_byte;
        end
        case (state_reg)
            S_FRAME:
            begin
                px_reg    <= fx;
                py_reg    <= fy;
                pol_reg   <= fpol;
                stamp_reg <= fstamp;
                stat_reg  <= fsync ? ST_SYNC : (fback ? ST_BACKWARD : ST_VALID);
                incl_reg  <= 1'b0;
                pos_reg   <= 26'sd0;
                ev_reg    <= 1'b0;
                if (plen != 3'd0)
                begin
                    // shift the window down by the dropped bytes
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (i + int'(drop) < DEPTH)
                            win_reg[i] <= win_reg[i + int'(drop)];
                    end
                end
            end
            S_DX:  acc_reg <= mp;
            S_DY:  acc_reg <= acc_reg + mp;
            S_CMP:
                incl_reg <= (acc_reg < 50'(signed'({1'b0, cfg_reg.radius_squared, 16'd0})));
            S_BX0: acc_reg <= mp;
            S_BY0: acc_reg <= mp;
            S_POS: if (incl_reg) pos_reg <= pos_next;
            S_ERR:
                if (incl_reg)
                    ev_reg <= ((perr < 0) ? -perr : perr) >= 27'(cfg_reg.event_threshold);
            default: ;
        endcase
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            status      <= stat_reg;
            pixel_x     <= px_reg;
            pixel_y     <= py_reg;
            polarity    <= pol_reg;
            stamp       <= stamp_reg;
            in_cluster  <= incl_reg;
            cluster_x   <= tx_reg;
            cluster_y   <= ty_reg;
            position_mm <= (pos_reg > 26'sd8388607) ? 24'sh7FFFFF :
                           ((pos_reg < -26'sd8388608) ? 24'sh800000 : pos_reg[23:0]);
            send_event  <= ev_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ sv/ecct_checker.sv @@
// ---------------------------------------------------------------------------
// ecct_checker: port level checks of the cluster tracker
// Watches handshakes and result fields over time.
// ---------------------------------------------------------------------------
`default_nettype none
module ecct_checker
    import ecct_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic        in_cluster,
    input wire logic        send_event,
    input wire logic [23:0] position_mm
);
    // accepting a byte always blocks the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("no busy after beat");
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    // error results never join the cluster
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_VALID) |-> !in_cluster) else $error("error in cluster");
    // outside the cluster there is no event and no position
    a_noev: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_cluster) |-> (!send_event && position_mm == 24'd0))
        else $error("event outside cluster");
endmodule

bind event_camera_cluster_tracker ecct_checker u_ecct_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .in_cluster(in_cluster), .send_event(send_event), .position_mm(position_mm)
);
`default_nettype wire
